>>> hdl/ohm_pkg.sv
`timescale 1ns / 1ps

package ohm_pkg;

  // Sizes of the stores and of the fields.
  localparam int ENTRY_SLOTS = 256;
  localparam int INDEX_SLOTS = 512;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int ENT_W  = $clog2(ENTRY_SLOTS);
  localparam int IDX_W  = $clog2(INDEX_SLOTS);
  localparam int CNT_W  = ENT_W + 1;
  localparam int SLOT_W = 10;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  // Index slot codes; a value below ENTRY_SLOTS points at an entry.
  localparam logic [SLOT_W-1:0] SLOT_EMPTY = '1;
  localparam logic [SLOT_W-1:0] SLOT_TOMB  = SLOT_EMPTY - SLOT_W'(1);

  // Multiplicative hash constant, split so no product exceeds 32 by 32 bits.
  localparam logic [63:0]      HASH_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [31:0]      HASH_LO  = HASH_MUL[31:0];
  localparam logic [IDX_W-1:0] HASH_HI  = HASH_MUL[32 +: IDX_W];

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_HASH1,
    S_HASH2,
    S_PIDX,
    S_PKEY,
    S_CSWEEP,
    S_CRD,
    S_CMV,
    S_RESP
  } state_t;

endpackage

>>> hdl/ohm_if.sv
`timescale 1ns / 1ps

// Request channel: one map operation per word.
interface ohm_req_if;
  import ohm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

// Response channel: one result word per operation.
interface ohm_rsp_if;
  import ohm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [VALUE_BITS-1:0] value_out;
  logic [CNT_W-1:0]      live_entries;
  modport source (output valid, status, value_out, live_entries, input ready);
  modport sink   (input valid, status, value_out, live_entries, output ready);
endinterface

>>> hdl/ohm_ram.sv
`timescale 1ns / 1ps

module ohm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ohm_hash.sv
`timescale 1ns / 1ps

module ohm_hash (
  input  logic                         clk,
  input  logic [ohm_pkg::KEY_BITS-1:0] key,
  output logic [ohm_pkg::IDX_W-1:0]    home
);
  import ohm_pkg::*;

  logic [63:0]      prod_lo;
  logic [IDX_W-1:0] prod_hi;
  logic [IDX_W-1:0] lo_low;
  logic [IDX_W-1:0] lo_up;
  logic [IDX_W-1:0] hi_q;

  // The low bits of key times the constant, in two partial products.
  assign prod_lo = 64'(key) * 64'(HASH_LO);
  assign prod_hi = key[IDX_W-1:0] * HASH_HI;

  always_ff @(posedge clk) begin
    lo_low <= prod_lo[IDX_W-1:0];
    lo_up  <= prod_lo[32 +: IDX_W];
    hi_q   <= prod_hi;
  end

  // Fold the upper word onto the lower one and keep the slot bits.
  assign home = lo_low ^ (lo_up + hi_q);

endmodule

>>> hdl/ordered_hash_map_engine.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields                             Handshake
// req      in   mode, key, value                   valid / ready
// rsp      out  status, value_out, live_entries    valid / ready
//
// A result word is ready once the key is hashed and the index is probed from the home
// slot: each tombstone or slot of a removed entry passed takes an index read, any other
// occupied slot also an entry read to compare keys; the index memory's single read port
// sets that pace. Get or remove on an empty map skips the probe; clear passes S_CLR.
// After reset, and after a clear, the index is swept to empty before a word is taken.
// A set that finds the store full first sweeps the index, then moves each live entry to
// the front with its own probe, skips each dead one, and retries.
// A stalled response holds; the next word may be taken while it waits.

module ordered_hash_map_engine (
  input logic clk,
  input logic rst,
  ohm_req_if.sink   req,
  ohm_rsp_if.source rsp
);
  import ohm_pkg::*;

  state_t state, state_next;

  logic [MODE_W-1:0]     op_mode;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_val;
  logic [KEY_BITS-1:0]   hkey;
  logic                  placing;
  logic                  compacted;
  logic [IDX_W-1:0]      p;
  logic [IDX_W-1:0]      pcnt;
  logic [ENT_W-1:0]      eidx;
  logic [CNT_W-1:0]      live_cnt;
  logic [CNT_W-1:0]      dead_cnt;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      ci;
  logic [CNT_W-1:0]      wp;
  logic [CNT_W-1:0]      used_c;
  logic [ENTRY_SLOTS-1:0] live_vec;
  logic                  sweep_busy;
  logic [IDX_W-1:0]      sweep_cnt;
  logic [STAT_W-1:0]     res_status;
  logic [VALUE_BITS-1:0] res_vout;
  logic                  out_valid;

  logic [IDX_W-1:0]      home;
  logic                  idx_we;
  logic [IDX_W-1:0]      idx_waddr;
  logic [SLOT_W-1:0]     idx_wdata;
  logic [IDX_W-1:0]      idx_raddr;
  logic [SLOT_W-1:0]     idx_rdata;
  logic                  ent_we;
  logic [ENT_W-1:0]      ent_waddr;
  logic [KEY_BITS+VALUE_BITS-1:0] ent_wdata;
  logic [ENT_W-1:0]      ent_raddr;
  logic [KEY_BITS+VALUE_BITS-1:0] ent_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  logic accept;
  logic v_empty;
  logic v_entry;
  logic key_match;
  logic advance;
  logic exhausted;
  logic miss_free;
  logic hit;
  logic resolve_miss;
  logic store_full;
  logic resp_go;

  ohm_hash u_hash (
    .clk  (clk),
    .key  (hkey),
    .home (home)
  );

  ohm_ram #(.DEPTH(INDEX_SLOTS), .WIDTH(SLOT_W)) u_index (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  ohm_ram #(.DEPTH(ENTRY_SLOTS), .WIDTH(KEY_BITS + VALUE_BITS)) u_entry (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign rd_key = ent_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_val = ent_rdata[VALUE_BITS-1:0];

  // Probe decisions on the slot and entry just read.
  assign accept     = req.valid && req.ready;
  assign used       = live_cnt + dead_cnt;
  assign store_full = used >= CNT_W'(ENTRY_SLOTS);
  assign v_empty    = idx_rdata == SLOT_EMPTY;
  assign v_entry    = !placing && idx_rdata != SLOT_TOMB
                      && idx_rdata < SLOT_W'(ENTRY_SLOTS)
                      && live_vec[idx_rdata[ENT_W-1:0]];
  assign key_match  = rd_key == op_key;
  assign advance    = (state == S_PIDX && !v_empty && !v_entry)
                      || (state == S_PKEY && !key_match);
  assign exhausted  = advance && pcnt == IDX_W'(INDEX_SLOTS - 1);
  assign miss_free  = state == S_PIDX && v_empty;
  assign resolve_miss = miss_free || exhausted;
  assign hit        = state == S_PKEY && key_match;
  assign resp_go    = state == S_RESP && (!out_valid || rsp.ready);

  assign req.ready = state == S_IDLE && !sweep_busy;

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    idx_we     = sweep_busy;
    idx_waddr  = sweep_cnt;
    idx_wdata  = SLOT_EMPTY;
    idx_raddr  = p;
    ent_we     = 1'b0;
    ent_waddr  = used[ENT_W-1:0];
    ent_wdata  = {op_key, op_val};
    ent_raddr  = idx_rdata[ENT_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_CLEAR) begin
            state_next = S_CLR;
          end else if (req.mode != MODE_SET && live_cnt == '0) begin
            state_next = S_RESP;
          end else begin
            state_next = S_HASH1;
          end
        end
      end
      S_CLR: state_next = S_RESP;
      S_HASH1: state_next = S_HASH2;
      S_HASH2: begin
        idx_raddr  = home;
        state_next = S_PIDX;
      end
      S_PIDX, S_PKEY: begin
        if (hit) begin
          if (op_mode == MODE_SET) begin
            ent_we    = 1'b1;
            ent_waddr = eidx;
          end else if (op_mode == MODE_REMOVE) begin
            idx_we    = 1'b1;
            idx_waddr = p;
            idx_wdata = SLOT_TOMB;
          end
          state_next = S_RESP;
        end else if (resolve_miss) begin
          if (placing) begin
            if (miss_free) begin
              idx_we    = 1'b1;
              idx_waddr = p;
              idx_wdata = SLOT_W'(wp);
            end
            state_next = S_CRD;
          end else if (op_mode != MODE_SET) begin
            state_next = S_RESP;
          end else if (store_full) begin
            state_next = compacted ? S_RESP : S_CSWEEP;
          end else if (miss_free) begin
            ent_we     = 1'b1;
            idx_we     = 1'b1;
            idx_waddr  = p;
            idx_wdata  = SLOT_W'(used);
            state_next = S_RESP;
          end else begin
            state_next = S_RESP;
          end
        end else if (advance) begin
          idx_raddr  = p + IDX_W'(1);
          state_next = S_PIDX;
        end else begin
          state_next = S_PKEY;
        end
      end
      S_CSWEEP: begin
        if (!sweep_busy) begin
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        ent_raddr = ci[ENT_W-1:0];
        if (ci == used_c) begin
          state_next = S_HASH1;
        end else if (live_vec[ci[ENT_W-1:0]]) begin
          state_next = S_CMV;
        end
      end
      S_CMV: begin
        ent_we     = 1'b1;
        ent_waddr  = wp[ENT_W-1:0];
        ent_wdata  = ent_rdata;
        state_next = S_HASH1;
      end
      S_RESP: begin
        if (resp_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: counters, live bits and the index sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      live_vec   <= '0;
      live_cnt   <= '0;
      dead_cnt   <= '0;
      sweep_busy <= 1'b1;
      sweep_cnt  <= '0;
      out_valid  <= 1'b0;
      placing    <= 1'b0;
      compacted  <= 1'b0;
    end else begin
      if (sweep_busy) begin
        sweep_cnt <= sweep_cnt + IDX_W'(1);
        if (sweep_cnt == IDX_W'(INDEX_SLOTS - 1)) begin
          sweep_busy <= 1'b0;
        end
      end
      if (resp_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            placing   <= 1'b0;
            compacted <= 1'b0;
          end
        end
        S_CLR: begin
          live_vec   <= '0;
          live_cnt   <= '0;
          dead_cnt   <= '0;
          sweep_busy <= 1'b1;
          sweep_cnt  <= '0;
        end
        S_PIDX, S_PKEY: begin
          if (hit && op_mode == MODE_REMOVE) begin
            live_vec[eidx] <= 1'b0;
            dead_cnt       <= dead_cnt + CNT_W'(1);
            live_cnt       <= live_cnt - CNT_W'(1);
          end else if (resolve_miss && !placing && op_mode == MODE_SET) begin
            if (store_full && !compacted) begin
              sweep_busy <= 1'b1;
              sweep_cnt  <= '0;
            end else if (!store_full && miss_free) begin
              live_vec[used[ENT_W-1:0]] <= 1'b1;
              live_cnt <= live_cnt + CNT_W'(1);
            end
          end
        end
        S_CRD: begin
          if (ci == used_c) begin
            live_cnt  <= wp;
            dead_cnt  <= '0;
            compacted <= 1'b1;
            placing   <= 1'b0;
          end
        end
        S_CMV: begin
          // An entry that stays in place keeps its live bit.
          if (ci != wp) begin
            live_vec[ci[ENT_W-1:0]] <= 1'b0;
          end
          live_vec[wp[ENT_W-1:0]] <= 1'b1;
          placing <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Operation payload, probe position and compaction pointers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_mode    <= req.mode;
          op_key     <= req.key;
          op_val     <= req.value;
          hkey       <= req.key;
          res_vout   <= '0;
          res_status <= (req.mode != MODE_SET && req.mode != MODE_CLEAR
                         && live_cnt == '0) ? ST_MISS : ST_OK;
        end
      end
      S_HASH2: begin
        p    <= home;
        pcnt <= '0;
      end
      S_PIDX, S_PKEY: begin
        if (hit) begin
          if (op_mode != MODE_SET) begin
            res_vout <= rd_val;
          end
        end else if (resolve_miss) begin
          if (placing) begin
            wp <= wp + CNT_W'(1);
            ci <= ci + CNT_W'(1);
          end else if (op_mode != MODE_SET) begin
            res_status <= ST_MISS;
          end else if (store_full) begin
            if (compacted) begin
              res_status <= ST_FULL;
            end
          end else if (!miss_free) begin
            res_status <= ST_FULL;
          end
        end else if (advance) begin
          p    <= p + IDX_W'(1);
          pcnt <= pcnt + IDX_W'(1);
        end else begin
          eidx <= idx_rdata[ENT_W-1:0];
        end
      end
      S_CSWEEP: begin
        ci     <= '0;
        wp     <= '0;
        used_c <= used;
      end
      S_CRD: begin
        if (ci == used_c) begin
          hkey <= op_key;
        end else if (!live_vec[ci[ENT_W-1:0]]) begin
          ci <= ci + CNT_W'(1);
        end
      end
      S_CMV: begin
        hkey <= rd_key;
      end
      default: ;
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (resp_go) begin
      rsp.status       <= res_status;
      rsp.value_out    <= res_vout;
      rsp.live_entries <= live_cnt;
    end
  end

  assign rsp.valid = out_valid;

endmodule

>>> test/ohm_checker.sv
`timescale 1ns / 1ps

module ohm_checker
  import ohm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ohm_req_if   req,
  ohm_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);

  // One expected result word.
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      live_entries;
  } map_result_t;

  localparam int IX_EMPTY = -1;
  localparam int IX_TOMB  = -2;

  // Shadow copy of the map.
  bit                    shadow_live[ENTRY_SLOTS];
  logic [KEY_BITS-1:0]   shadow_key[ENTRY_SLOTS];
  logic [VALUE_BITS-1:0] shadow_value[ENTRY_SLOTS];
  int                    shadow_index[INDEX_SLOTS];
  int                    live_total;
  int                    dead_total;
  map_result_t           pending_results[$];

  assign outstanding = pending_results.size();

  function automatic int start_slot(logic [KEY_BITS-1:0] key);
    logic [63:0] h;
    h = 64'(key) * HASH_MUL;
    h = h ^ (h >> 32);
    return int'(h % INDEX_SLOTS);
  endfunction

  function automatic void empty_map();
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      shadow_live[i]  = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    for (int i = 0; i < INDEX_SLOTS; i++) shadow_index[i] = IX_EMPTY;
    live_total = 0;
    dead_total = 0;
  endfunction

  // Returns 1 on a hit, 0 on a miss with a free slot, -1 when no slot is free.
  function automatic int lookup(input logic [KEY_BITS-1:0] key, output int slot,
                                output int entry);
    int p;
    int v;
    p = start_slot(key);
    slot = 0;
    entry = 0;
    for (int i = 0; i < INDEX_SLOTS; i++) begin
      v = shadow_index[p];
      if (v == IX_EMPTY) begin
        slot = p;
        return 0;
      end
      if (v >= 0 && v < ENTRY_SLOTS && shadow_live[v] && shadow_key[v] == key) begin
        slot = p;
        entry = v;
        return 1;
      end
      p = (p + 1) % INDEX_SLOTS;
    end
    return -1;
  endfunction

  // Moves live entries to the front in order and rebuilds the index.
  function automatic void squeeze_store();
    int used;
    int w;
    int p;
    used = live_total + dead_total;
    if (used > ENTRY_SLOTS) used = ENTRY_SLOTS;
    w = 0;
    for (int i = 0; i < INDEX_SLOTS; i++) shadow_index[i] = IX_EMPTY;
    for (int i = 0; i < used; i++) begin
      if (shadow_live[i]) begin
        shadow_key[w]   = shadow_key[i];
        shadow_value[w] = shadow_value[i];
        shadow_live[w]  = 1'b1;
        p = start_slot(shadow_key[w]);
        for (int k = 0; k < INDEX_SLOTS; k++) begin
          if (shadow_index[p] == IX_EMPTY) begin
            shadow_index[p] = w;
            break;
          end
          p = (p + 1) % INDEX_SLOTS;
        end
        w++;
      end
    end
    for (int i = w; i < ENTRY_SLOTS; i++) shadow_live[i] = 1'b0;
    live_total = w;
    dead_total = 0;
  endfunction

  // Applies one operation to the shadow map and returns its result word.
  function automatic map_result_t apply_op(logic [MODE_W-1:0] mode,
                                           logic [KEY_BITS-1:0] key,
                                           logic [VALUE_BITS-1:0] value);
    map_result_t res;
    int r;
    int slot;
    int entry;
    int e;
    res = '0;
    case (mode)
      MODE_SET: begin
        r = lookup(key, slot, entry);
        if (r == 1) begin
          shadow_value[entry] = value;
        end else begin
          if (live_total + dead_total >= ENTRY_SLOTS) begin
            squeeze_store();
            r = lookup(key, slot, entry);
          end
          if (live_total + dead_total >= ENTRY_SLOTS || r != 0) begin
            res.status = ST_FULL;
          end else begin
            e = live_total + dead_total;
            shadow_live[e]  = 1'b1;
            shadow_key[e]   = key;
            shadow_value[e] = value;
            shadow_index[slot] = e;
            live_total++;
          end
        end
      end
      MODE_GET, MODE_REMOVE: begin
        r = (live_total == 0) ? 0 : lookup(key, slot, entry);
        if (r != 1) begin
          res.status = ST_MISS;
        end else begin
          res.value_out = shadow_value[entry];
          if (mode == MODE_REMOVE) begin
            shadow_index[slot] = IX_TOMB;
            shadow_live[entry] = 1'b0;
            dead_total++;
            live_total--;
          end
        end
      end
      default: begin
        empty_map();
      end
    endcase
    res.live_entries = CNT_W'(live_total);
    return res;
  endfunction

  // Predict on each accepted request word, compare on each accepted result word.
  always @(posedge clk) begin
    map_result_t want;
    if (rst) begin
      empty_map();
      pending_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        pending_results.push_back(apply_op(req.mode, req.key, req.value));
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: status %0d value_out %h live_entries %0d",
                 rsp.status, rsp.value_out, rsp.live_entries);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, rsp.value_out);
            fail_count++;
          end
          if (rsp.live_entries !== want.live_entries) begin
            $error("live_entries: expected %0d, got %0d", want.live_entries,
                   rsp.live_entries);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    empty_map();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ohm_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int POOL_SIZE   = 400;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic [KEY_BITS-1:0] key_pool[POOL_SIZE];

  ohm_req_if req ();
  ohm_rsp_if rsp ();

  ordered_hash_map_engine i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ohm_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side stalls at random with the current rate.
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one request word and waits until it is taken.
  task automatic send_op(logic [MODE_W-1:0] mode, logic [KEY_BITS-1:0] key,
                         logic [VALUE_BITS-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.mode  <= mode;
    req.key   <= key;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key(int lo, int hi);
    return key_pool[$urandom_range(hi, lo)];
  endfunction

  initial begin
    int roll;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.mode       = MODE_SET;
    req.key        = '0;
    req.value      = '0;
    rsp.ready      = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty map, key and value extremes, update, remove, clear.
    send_op(MODE_GET,    32'h0,        32'h0);
    send_op(MODE_REMOVE, 32'hFFFFFFFF, 32'h0);
    send_op(MODE_SET,    32'h0,        32'hFFFFFFFF);
    send_op(MODE_SET,    32'hFFFFFFFF, 32'h0);
    send_op(MODE_GET,    32'h0,        32'h12345678);
    send_op(MODE_GET,    32'hFFFFFFFF, 32'h0);
    send_op(MODE_SET,    32'h0,        32'hA5A5A5A5);
    send_op(MODE_GET,    32'h0,        32'h0);
    send_op(MODE_GET,    32'h1,        32'h0);
    send_op(MODE_REMOVE, 32'h0,        32'h0);
    send_op(MODE_GET,    32'h0,        32'h0);
    send_op(MODE_REMOVE, 32'h0,        32'h0);
    send_op(MODE_SET,    32'h0,        32'h5A5A5A5A);
    send_op(MODE_GET,    32'h0,        32'h0);
    send_op(MODE_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF);
    send_op(MODE_GET,    32'hFFFFFFFF, 32'h0);
    send_op(MODE_SET,    32'h80000000, 32'h00000001);

    // Fill the store past its capacity, so that late sets report full.
    for (int i = 0; i < 270; i++) send_op(MODE_SET, key_pool[i], $urandom());
    send_op(MODE_SET, key_pool[3], 32'hFFFFFFFF);

    // Sender idling: mostly removals, leaving tombstones behind.
    send_idle_pct = 70;
    for (int i = 0; i < 90; i++) begin
      if ($urandom_range(99) < 70) send_op(MODE_REMOVE, pick_key(0, 269), $urandom());
      else send_op(MODE_GET, pick_key(0, 269), $urandom());
    end

    // Receiver stalling: new keys force compaction of the dead entries.
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    for (int i = 0; i < 90; i++) begin
      roll = $urandom_range(99);
      if (roll < 60) send_op(MODE_SET, pick_key(270, POOL_SIZE - 1), $urandom());
      else if (roll < 80) send_op(MODE_GET, pick_key(0, POOL_SIZE - 1), $urandom());
      else send_op(MODE_REMOVE, pick_key(0, POOL_SIZE - 1), $urandom());
    end

    // Both sides idling: general mix with an occasional clear.
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    for (int i = 0; i < 90; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) send_op(MODE_CLEAR, $urandom(), $urandom());
      else if (roll < 45) send_op(MODE_SET, pick_key(0, 59), $urandom());
      else if (roll < 75) send_op(MODE_GET, pick_key(0, 59), $urandom());
      else if (roll < 95) send_op(MODE_REMOVE, pick_key(0, 59), $urandom());
      else send_op(MODE_GET, $urandom(), $urandom());
    end

    @(negedge clk);
    req.valid <= 1'b0;
    recv_stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> ordered_hash_map_engine.f
hdl/ohm_pkg.sv
hdl/ohm_if.sv
hdl/ohm_ram.sv
hdl/ohm_hash.sv
hdl/ordered_hash_map_engine.sv
test/ohm_checker.sv
test/tb.sv
